>>> hw/rtl/acwk_pkg.sv
// ----------------------------------------------------------------------------
// acwk_pkg
// Shared types and constants for the alarm clock with keypad entry.
// ----------------------------------------------------------------------------
`default_nettype none

package acwk_pkg;

  // Item commands
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_KEY    = 2'd1;
  localparam logic [1:0] CMD_SNOOZE = 2'd2;

  // Keypad positions
  localparam logic [3:0] KEY_DIGIT_FIRST = 4'd0;   // digit 1
  localparam logic [3:0] KEY_DIGIT_LAST  = 4'd8;   // digit 9
  localparam logic [3:0] KEY_SET_TIME    = 4'd9;
  localparam logic [3:0] KEY_DIGIT_ZERO  = 4'd10;
  localparam logic [3:0] KEY_SET_ALARM   = 4'd11;

  // Time constants
  localparam int unsigned SecsPerMin    = 60;
  localparam int unsigned MinsPerHour   = 60;
  localparam int unsigned HoursPerDay   = 24;
  localparam int unsigned SnoozeMinutes = 2;
  localparam int unsigned EntryLen      = 4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] key_position;
    logic       stop_held;
  } in_t;

  typedef struct packed {
    logic [4:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
    logic [4:0] alarm_hours;
    logic [5:0] alarm_minutes;
    logic       alarm_armed;
    logic       clock_running;
    logic       buzzer_on;
  } out_t;

  // Clock state; entry[0] is the newest digit
  typedef struct packed {
    logic [5:0]                sec_count;
    logic [5:0]                min_count;
    logic [4:0]                hour_count;
    logic [5:0]                alm_minute;
    logic [4:0]                alm_hour;
    logic                      alm_enabled;
    logic                      started;
    logic [EntryLen-1:0][3:0]  entry;
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/alarm_clock_with_keypad_entry_core.sv
// ----------------------------------------------------------------------------
// alarm_clock_with_keypad_entry_core
// 24-hour alarm clock driven by tick, key and snooze items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one item per
//   cycle: a one-second tick, a keypad press or a snooze press, with the
//   level of the stop button. Each item yields exactly one result on the
//   output channel (out_valid_o / out_ready_i / out_data_o) that reports
//   time, alarm setting, flags and the buzzer level after the item.
//   The item lands in an input register, then the state update and result
//   are computed in one pass and written into the state and result
//   registers. Throughput is one item per cycle while out_ready_i is high.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, then in_ready_o drops until the result drains.
//   Reset clears the time, the alarm, both flags and the digit entry, and
//   leaves both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_clock_with_keypad_entry_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  acwk_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output acwk_pkg::out_t   out_data_o
);
  import acwk_pkg::*;

  logic   s1_valid_q;
  in_t    s1_item_q;
  logic   s1_adv;
  state_t state_q;
  state_t state_d;
  logic   res_valid_q;
  out_t   res_q;
  out_t   res_d;

  // Move the held item on when the result register is free
  assign s1_adv     = s1_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Hold the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
  end

  acwk_step u_step (
    .cur_i  (state_q),
    .item_i (s1_item_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  // Advance the clock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // Drop a taken result, load a new one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/acwk_step.sv
// ----------------------------------------------------------------------------
// acwk_step
// Next-state and result logic for one item of the alarm clock.
// ----------------------------------------------------------------------------
`default_nettype none

module acwk_step (
  input  acwk_pkg::state_t cur_i,
  input  acwk_pkg::in_t    item_i,
  output acwk_pkg::state_t nxt_o,
  output acwk_pkg::out_t   res_o
);
  import acwk_pkg::*;

  // Fold an hour value below 101 into 0..23
  function automatic logic [4:0] hour_mod24(input logic [6:0] h);
    logic [6:0] t;
    begin
      t = h;
      if (t >= 7'(4 * HoursPerDay)) t = t - 7'(4 * HoursPerDay);
      if (t >= 7'(2 * HoursPerDay)) t = t - 7'(2 * HoursPerDay);
      if (t >= 7'(HoursPerDay))     t = t - 7'(HoursPerDay);
      return t[4:0];
    end
  endfunction

  logic [6:0] ld_hour_raw;
  logic [6:0] ld_min_raw;
  logic [6:0] ld_hour_fix;
  logic [5:0] ld_min_fix;
  logic [4:0] ld_hour;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [6:0] snz_min;
  logic       match_cur;
  logic       match_nxt;
  state_t     nxt;

  // Split the entry as hhmm and repair minutes and hours
  always_comb begin
    ld_hour_raw = 7'(cur_i.entry[3]) * 7'd10 + 7'(cur_i.entry[2]);
    ld_min_raw  = 7'(cur_i.entry[1]) * 7'd10 + 7'(cur_i.entry[0]);
    if (ld_min_raw >= 7'(MinsPerHour)) begin
      ld_min_fix  = 6'(ld_min_raw - 7'(MinsPerHour));
      ld_hour_fix = ld_hour_raw + 7'd1;
    end else begin
      ld_min_fix  = ld_min_raw[5:0];
      ld_hour_fix = ld_hour_raw;
    end
    ld_hour = hour_mod24(ld_hour_fix);
  end

  assign sec_inc   = 7'(cur_i.sec_count) + 7'd1;
  assign min_inc   = 7'(cur_i.min_count) + 7'd1;
  assign snz_min   = 7'(cur_i.alm_minute) + 7'(SnoozeMinutes);
  assign match_cur = cur_i.alm_enabled && (cur_i.hour_count == cur_i.alm_hour) &&
                     (cur_i.min_count == cur_i.alm_minute);

  // Apply the item to the state
  always_comb begin
    nxt = cur_i;
    case (item_i.cmd)
      CMD_TICK: begin
        if (cur_i.started) begin
          if (sec_inc >= 7'(SecsPerMin)) begin
            nxt.sec_count = '0;
            if (min_inc >= 7'(MinsPerHour)) begin
              nxt.min_count  = '0;
              nxt.hour_count = hour_mod24(7'(cur_i.hour_count) + 7'd1);
            end else begin
              nxt.min_count = min_inc[5:0];
            end
          end else begin
            nxt.sec_count = sec_inc[5:0];
          end
        end
      end
      CMD_KEY: begin
        case (item_i.key_position) inside
          [KEY_DIGIT_FIRST:KEY_DIGIT_LAST]: begin
            nxt.entry = {cur_i.entry[2:0], item_i.key_position + 4'd1};
          end
          KEY_DIGIT_ZERO: begin
            nxt.entry = {cur_i.entry[2:0], 4'd0};
          end
          KEY_SET_TIME: begin
            nxt.hour_count = ld_hour;
            nxt.min_count  = ld_min_fix;
            nxt.started    = 1'b1;
            nxt.entry      = '0;
          end
          KEY_SET_ALARM: begin
            nxt.alm_hour    = ld_hour;
            nxt.alm_minute  = ld_min_fix;
            nxt.alm_enabled = 1'b1;
            nxt.entry       = '0;
          end
          default: begin
          end
        endcase
      end
      CMD_SNOOZE: begin
        if (!item_i.stop_held && match_cur) begin
          if (snz_min >= 7'(MinsPerHour)) begin
            nxt.alm_minute = 6'(snz_min - 7'(MinsPerHour));
            nxt.alm_hour   = hour_mod24(7'(cur_i.alm_hour) + 7'd1);
          end else begin
            nxt.alm_minute = snz_min[5:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Report the state after the item
  assign match_nxt = nxt.alm_enabled && (nxt.hour_count == nxt.alm_hour) &&
                     (nxt.min_count == nxt.alm_minute);

  assign nxt_o = nxt;

  always_comb begin
    res_o.hours_now     = nxt.hour_count;
    res_o.minutes_now   = nxt.min_count;
    res_o.seconds_now   = nxt.sec_count;
    res_o.alarm_hours   = nxt.alm_hour;
    res_o.alarm_minutes = nxt.alm_minute;
    res_o.alarm_armed   = nxt.alm_enabled;
    res_o.clock_running = nxt.started;
    res_o.buzzer_on     = match_nxt && !item_i.stop_held;
  end

endmodule

`default_nettype wire
